// ===== hw/rtl/position_keyed_byte_decrypt_top_assert.svh =====
// assertion macros used by the checker file of the block
`ifndef POSITION_KEYED_BYTE_DECRYPT_TOP_ASSERT_SVH
`define POSITION_KEYED_BYTE_DECRYPT_TOP_ASSERT_SVH

// antecedent holds, consequent in the same cycle
`define PKBD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent in the next cycle
`define PKBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// property checked without a disable condition
`define PKBD_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pkbd_pkg.sv =====
// package: register indexes, constants and key helper functions
`timescale 1ns / 1ps

package pkbd_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned PositionWidth = 64;
   localparam int unsigned CsrDataWidth = 64;
   localparam logic [ByteWidth-1:0] TableBLast = 8'h6B;
   localparam logic [4:0] TableBLastIndex = 5'd16;

   typedef enum logic [1:0] {
      CSR_TABLE_A_LOW  = 2'd0,
      CSR_TABLE_A_HIGH = 2'd1,
      CSR_TABLE_B_LOW  = 2'd2,
      CSR_TABLE_B_HIGH = 2'd3
   } csr_index_type;

   // position mod 17: 256 is 1 mod 17 and 16 is -1 mod 17
   function automatic logic [4:0] pos_mod17(input logic [PositionWidth-1:0] pos);
      logic [10:0] byte_sum;
      logic [8:0] fold;
      logic signed [5:0] diff;
      byte_sum = '0;
      for (int k = 0; k < 8; k++) begin
         byte_sum = byte_sum + {3'b000, pos[8*k +: 8]};
      end
      fold = {1'b0, byte_sum[7:0]} + {6'b000000, byte_sum[10:8]};
      diff = $signed({2'b00, fold[3:0]}) - $signed({2'b00, fold[7:4]})
             + $signed({5'b00000, fold[8]});
      if (diff < 0) begin
         diff = diff + 6'sd17;
      end
      return diff[4:0];
   endfunction

   // byte idx of a 16-byte table held as two 64-bit words
   function automatic logic [ByteWidth-1:0] table_byte(input logic [63:0] lo,
                                                       input logic [63:0] hi,
                                                       input logic [3:0] idx);
      logic [63:0] word;
      word = idx[3] ? hi : lo;
      return word[8*idx[2:0] +: 8];
   endfunction

   // xor of the four bytes of the low 32 bits of the position
   function automatic logic [ByteWidth-1:0] key_fold(input logic [PositionWidth-1:0] pos);
      return pos[7:0] ^ pos[15:8] ^ pos[23:16] ^ pos[31:24];
   endfunction

endpackage

// ===== hw/rtl/position_keyed_byte_decrypt_top.sv =====
// position keyed byte decrypt: top level
//
// input channel req_*: one cipher byte, its 64-bit key position and an end
// marker per transfer; a transfer happens when req_valid is high and
// req_stall is low. result channel rsp_*: the plain byte and the copied end
// marker, with the same valid/stall rule.
// tables A and B are loaded through csr_write_enable / csr_index /
// csr_write_data; the user must load them only while the block is idle, and
// the block itself does not enforce this. byte 16 of table B is fixed.
// a request taken goes into the input register, then the result register,
// from which it can transfer out. throughput: one byte per cycle while
// rsp_stall is low; the mod-17 table index, the table muxes and the xor
// chain sit between the two registers. a stalled result holds rsp_* steady;
// the input register can still take one request while the result waits,
// and req_stall rises only when both registers are full and rsp_stall is high.
// reset (synchronous) empties both registers and clears all tables to zero.
`timescale 1ns / 1ps

module position_keyed_byte_decrypt_top
   import pkbd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ByteWidth-1:0]     req_byte_in,
   input  logic [PositionWidth-1:0] req_position,
   input  logic                     req_end_of_block,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ByteWidth-1:0]     rsp_byte_out,
   output logic                     rsp_end_of_block_out,
   input  logic                     csr_write_enable,
   input  csr_index_type            csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   logic [63:0] table_a_low_ff, table_a_high_ff, table_b_low_ff, table_b_high_ff;

   logic                     s1_valid_ff;
   logic [ByteWidth-1:0]     s1_byte_ff;
   logic [PositionWidth-1:0] s1_position_ff;
   logic                     s1_eob_ff;

   logic                 rsp_valid_ff;
   logic [ByteWidth-1:0] rsp_byte_ff;
   logic                 rsp_eob_ff;

   logic rsp_load;
   logic req_take;
   logic [4:0] b_index;
   logic [ByteWidth-1:0] b_key;
   logic [ByteWidth-1:0] after_b;
   logic [ByteWidth-1:0] after_nibble;
   logic [ByteWidth-1:0] rsp_byte_in;

   // result register is free when empty or its transfer completes now
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !rsp_load;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_a_low_ff  <= '0;
         table_a_high_ff <= '0;
         table_b_low_ff  <= '0;
         table_b_high_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TABLE_A_LOW:  table_a_low_ff  <= csr_write_data;
            CSR_TABLE_A_HIGH: table_a_high_ff <= csr_write_data;
            CSR_TABLE_B_LOW:  table_b_low_ff  <= csr_write_data;
            CSR_TABLE_B_HIGH: table_b_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (rsp_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff     <= req_byte_in;
         s1_position_ff <= req_position;
         s1_eob_ff      <= req_end_of_block;
      end
   end

   always_comb begin
      b_index = pos_mod17(s1_position_ff);
      if (b_index == TableBLastIndex) begin
         b_key = TableBLast;
      end else begin
         b_key = table_byte(table_b_low_ff, table_b_high_ff, b_index[3:0]);
      end
      after_b      = s1_byte_ff ^ b_key;
      after_nibble = after_b ^ {after_b[3:0], 4'b0000};
      rsp_byte_in  = after_nibble
                     ^ table_byte(table_a_low_ff, table_a_high_ff, s1_position_ff[3:0])
                     ^ key_fold(s1_position_ff);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && s1_valid_ff) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_eob_ff  <= s1_eob_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_byte_out         = rsp_byte_ff;
   assign rsp_end_of_block_out = rsp_eob_ff;

endmodule

// ===== hw/rtl/pkbd_checker.sv =====
// port-level checker for the decrypt block, bound to the top level
`timescale 1ns / 1ps
`include "position_keyed_byte_decrypt_top_assert.svh"

module pkbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_byte_out,
   input logic       rsp_end_of_block_out
);

   // a stalled result holds its data
   `PKBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_byte_out) && $stable(rsp_end_of_block_out), "result changed while stalled")

   // reset empties the result register
   `PKBD_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result valid right after reset")

   // a new result only follows a request transfer that passed the input register
   `PKBD_ASSERT_SAME(a_no_invent, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without a request transfer")

   // input side only backs up behind a stalled result
   `PKBD_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled with result side free")

endmodule

bind position_keyed_byte_decrypt_top pkbd_checker u_pkbd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_byte_out         (rsp_byte_out),
   .rsp_end_of_block_out (rsp_end_of_block_out)
);

// ===== bench/testbench.sv =====
// testbench for the position keyed byte decrypt block: table-driven and random checks
`timescale 1ns / 1ps

module testbench;
   import pkbd_pkg::*;

   localparam int StallLimit = 2000;
   localparam int SegItems = 313;
   localparam int NumSegs = 6;
   localparam int NumRows = 18;

   typedef struct packed {
      logic [7:0]  cipher;
      logic [63:0] pos;
      logic        mark;
      logic        typed;
      logic [7:0]  plain;
   } dir_row_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       end_out;
   } plain_rec_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [ByteWidth-1:0]     req_byte_in;
   logic [PositionWidth-1:0] req_position;
   logic                     req_end_of_block;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [ByteWidth-1:0]     rsp_byte_out;
   logic                     rsp_end_of_block_out;
   logic                     csr_write_enable;
   csr_index_type            csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;

   // local copy of the key tables
   logic [63:0] tbl_a_lo, tbl_a_hi, tbl_b_lo, tbl_b_hi;

   plain_rec_type plain_q [$];
   plain_rec_type due_rec;
   int error_count = 0;
   int bytes_sent = 0;
   int bytes_checked = 0;
   int marks_sent = 0;
   int fixed_key_hits = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // rows with plain set were worked out by hand with all tables at zero
   dir_row_type dir_rows [NumRows] = '{
      '{8'h00, 64'h0000_0000_0000_0000, 1'b0, 1'b1, 8'h00},
      '{8'hFF, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 8'h0F},
      '{8'h0F, 64'h0000_0000_0000_0000, 1'b0, 1'b1, 8'hFF},
      '{8'hF0, 64'h0000_0000_0000_0000, 1'b0, 1'b1, 8'hF0},
      '{8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 8'h00},
      '{8'hA5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 8'hF5},
      '{8'h00, 64'h0000_0000_0000_0010, 1'b0, 1'b0, 8'h00},
      '{8'h3C, 64'h0000_0000_0000_0021, 1'b1, 1'b0, 8'h00},
      '{8'h01, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 8'h00},
      '{8'h10, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 8'h00},
      '{8'h80, 64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, 8'h00},
      '{8'h5A, 64'h0000_0001_0000_0000, 1'b0, 1'b0, 8'h00},
      '{8'hC3, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 1'b0, 8'h00},
      '{8'h7E, 64'hFFFF_FFFF_FFFF_FFEF, 1'b1, 1'b0, 8'h00},
      '{8'h02, 64'h0000_0000_8000_0000, 1'b0, 1'b0, 8'h00},
      '{8'h40, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 8'h00},
      '{8'hE7, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 8'h00},
      '{8'h99, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 8'h00}
   };

   position_keyed_byte_decrypt_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_byte_in          (req_byte_in),
      .req_position         (req_position),
      .req_end_of_block     (req_end_of_block),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_byte_out         (rsp_byte_out),
      .rsp_end_of_block_out (rsp_end_of_block_out),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // plain byte for a cipher byte at a key position, from the local tables
   function automatic logic [7:0] decrypt_at(input logic [7:0] cipher, input logic [63:0] pos);
      logic [127:0] key_a, key_b;
      logic [63:0]  idx17;
      logic [7:0]   kb, b;
      key_a = {tbl_a_hi, tbl_a_lo};
      key_b = {tbl_b_hi, tbl_b_lo};
      idx17 = pos % 64'd17;
      if (idx17 == 64'd16) begin
         kb = TableBLast;
      end else begin
         kb = key_b[8*idx17[3:0] +: 8];
      end
      b = cipher ^ kb;
      b = b ^ {b[3:0], 4'h0};
      b = b ^ key_a[8*pos[3:0] +: 8];
      b = b ^ pos[7:0] ^ pos[15:8] ^ pos[23:16] ^ pos[31:24];
      return b;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic load_table(input csr_index_type which, input logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= which;
      csr_write_data <= value;
      case (which)
         CSR_TABLE_A_LOW:  tbl_a_lo = value;
         CSR_TABLE_A_HIGH: tbl_a_hi = value;
         CSR_TABLE_B_LOW:  tbl_b_lo = value;
         CSR_TABLE_B_HIGH: tbl_b_hi = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // present one byte, wait for the transfer, then queue what should come back
   task automatic send_byte(input logic [7:0] cipher, input logic [63:0] pos, input logic mark,
                            input logic typed, input logic [7:0] plain);
      plain_rec_type rec;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= cipher;
      req_position <= pos;
      req_end_of_block <= mark;
      do @(posedge clock); while (req_stall);
      rec.data_out = typed ? plain : decrypt_at(cipher, pos);
      rec.end_out = mark;
      plain_q = {plain_q, rec};
      bytes_sent++;
      if (mark) marks_sent++;
      if (pos % 64'd17 == 64'd16) fixed_key_hits++;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (plain_q.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (plain_q.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_byte_out, 8'h00);
         end else begin
            due_rec = plain_q.pop_front();
            bytes_checked++;
            if (rsp_byte_out !== due_rec.data_out)
               report_mismatch("byte_out", rsp_byte_out, due_rec.data_out);
            if (rsp_end_of_block_out !== due_rec.end_out)
               report_mismatch("end_of_block_out", {7'h0, rsp_end_of_block_out},
                               {7'h0, due_rec.end_out});
         end
      end
   end

   // no transfer on either channel for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int seg, left, len, j;
      logic [63:0] base, value;
      req_valid = 1'b0;
      req_byte_in = '0;
      req_position = '0;
      req_end_of_block = 1'b0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_TABLE_A_LOW;
      csr_write_data = '0;
      tbl_a_lo = '0;
      tbl_a_hi = '0;
      tbl_b_lo = '0;
      tbl_b_hi = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tables untouched since reset: only the fixed table B byte is nonzero
      for (j = 0; j < NumRows; j++) begin
         send_byte(dir_rows[j].cipher, dir_rows[j].pos, dir_rows[j].mark,
                   dir_rows[j].typed, dir_rows[j].plain);
      end
      drain();

      for (seg = 0; seg < NumSegs; seg++) begin
         send_idle_pct = (seg < 2) ? 36 : (seg < 4) ? 54 : 0;
         recv_idle_pct = (seg < 2) ? 54 : (seg < 4) ? 36 : 0;
         for (j = 0; j < 4; j++) begin
            case (seg)
               0: value = 64'hFFFF_FFFF_FFFF_FFFF;
               2: value = j[1] ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA;
               4: value = 64'h0000_0000_0000_0000;
               default: value = {$urandom, $urandom};
            endcase
            load_table(csr_index_type'(j), value);
         end
         left = SegItems;
         while (left > 0) begin
            if ($urandom_range(0, 9) < 8) begin
               // a buffer: consecutive positions from a seed, marker on the last byte
               len = $urandom_range(1, 40);
               case ($urandom_range(0, 3))
                  0: base = {$urandom, $urandom};
                  1: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
                  2: base = 64'($urandom_range(0, 64));
                  default: base = {32'h0, $urandom};
               endcase
               for (int k = 0; k < len; k++) begin
                  send_byte(8'($urandom_range(0, 255)), base + 64'(k), k == len - 1,
                            1'b0, 8'h00);
               end
               left -= len;
            end else begin
               send_byte(8'($urandom_range(0, 255)), {$urandom, $urandom},
                         1'($urandom_range(0, 1)), 1'b0, 8'h00);
               left--;
            end
         end
         drain();
      end

      repeat (4) @(posedge clock);
      $display("covered %0d bytes (%0d checked) over %0d table settings and three stall mixes",
               bytes_sent, bytes_checked, NumSegs + 1);
      $display("%0d bytes carried the end marker, %0d used the fixed table B byte",
               marks_sent, fixed_key_hits);
      if (error_count == 0 && plain_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== position_keyed_byte_decrypt_top.f =====
+incdir+hw/rtl
hw/rtl/pkbd_pkg.sv
hw/rtl/position_keyed_byte_decrypt_top.sv
hw/rtl/pkbd_checker.sv
bench/testbench.sv
